### sv/knsel_pkg.sv
// Shared constants and types for the k-nearest selector.
`default_nettype none

package knsel_pkg;

  // keep_count register
  localparam int unsigned KEEP_W     = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  // default sizing of the core
  localparam int unsigned MAX_KEEP_DEF   = 16;
  localparam int unsigned MAX_POINTS_DEF = 4096;
  localparam int unsigned DIST_BITS_DEF  = 32;

  // per-cycle command from the core to every cell
  typedef struct packed {
    logic step;  // input request taken: insert broadcast distance
    logic pop;   // result request taken: shift list toward cell 0
  } knsel_ctl_t;

endpackage

`default_nettype wire

### sv/knsel_cell.sv
// One slot of the sorted insertion chain: holds one kept distance and its index.
`default_nettype none

module knsel_cell
  import knsel_pkg::*;
#(
  parameter int unsigned DIST_BITS = DIST_BITS_DEF,
  parameter int unsigned IDX_W     = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire knsel_ctl_t           ctl,
  input  wire logic                 en,         // slot lies below the current k
  input  wire logic [DIST_BITS-1:0] new_dist,
  input  wire logic [IDX_W-1:0]     new_idx,
  // lower neighbor (closer to the head)
  input  wire logic                 prev_valid,
  input  wire logic [DIST_BITS-1:0] prev_dist,
  input  wire logic [IDX_W-1:0]     prev_idx,
  input  wire logic                 prev_take,
  // upper neighbor (toward the tail)
  input  wire logic                 next_valid,
  input  wire logic [DIST_BITS-1:0] next_dist,
  input  wire logic [IDX_W-1:0]     next_idx,
  output logic                      valid_o,
  output logic [DIST_BITS-1:0]      dist_o,
  output logic [IDX_W-1:0]          idx_o,
  output logic                      take_o
);

  logic                 vld_r,  vld_nxt;
  logic [DIST_BITS-1:0] dist_r, dist_nxt;
  logic [IDX_W-1:0]     idx_r,  idx_nxt;

  // strict compare: an equal distance ranks behind the earlier point
  assign take_o = !vld_r || (new_dist < dist_r);

  always_comb begin
    vld_nxt  = vld_r;
    dist_nxt = dist_r;
    idx_nxt  = idx_r;
    if (ctl.pop) begin
      vld_nxt  = next_valid;
      dist_nxt = next_dist;
      idx_nxt  = next_idx;
    end else if (ctl.step) begin
      if (!en) begin
        vld_nxt = 1'b0;
      end else if (take_o && prev_take) begin
        // insertion point is below us: take the neighbor's entry
        vld_nxt  = prev_valid;
        dist_nxt = prev_dist;
        idx_nxt  = prev_idx;
      end else if (take_o) begin
        vld_nxt  = 1'b1;
        dist_nxt = new_dist;
        idx_nxt  = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    idx_r  <= idx_nxt;
  end

  assign valid_o = vld_r;
  assign dist_o  = dist_r;
  assign idx_o   = idx_r;

endmodule

`default_nettype wire

### sv/k_nearest_selector_core.sv
// Top level of the k-nearest selector: cell chain, arrival counter and readout control.
`default_nettype none

// Keeps the k smallest distances of a set, with their arrival positions, in a
// chain of MAX_KEEP cells sorted by ascending distance (equal distances keep
// arrival order). A distance is accepted every cycle while no readout runs and
// is inserted in that cycle by a broadcast compare across the chain. When the
// request marked tlast is taken, the input stalls and the kept entries are read
// out from the head cell one per cycle while the receiver is ready (the chain
// shifts toward the head on each taken result), the first in the cycle after
// that request; the run ends with tlast.
// keep_count is read as 1 when zero and is capped at MAX_KEEP.
module k_nearest_selector_core
  import knsel_pkg::*;
#(
  parameter int unsigned MAX_KEEP   = MAX_KEEP_DEF,
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned DIST_BITS  = DIST_BITS_DEF,
  localparam int unsigned IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned IN_W      = ((DIST_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((IDX_W + DIST_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wen,
  input  wire logic [KEEP_W-1:0] cfg_wdata,    // keep_count
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,     // [DIST_BITS-1:0] distance, zero pad
  input  wire logic              in_tlast,     // final_item
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,    // point_index, point_distance, zero pad
  output logic                   out_tlast     // last_result
);

  localparam logic [IDX_W-1:0] IDX_WRAP = IDX_W'(MAX_POINTS - 1);

  logic [KEEP_W-1:0] keep_count_r;
  logic [IDX_W-1:0]  arr_cnt_r, arr_cnt_nxt;
  logic              drain_r,   drain_nxt;

  logic              in_acc, out_acc;
  knsel_ctl_t        ctl;
  logic [DIST_BITS-1:0] new_dist;

  logic [MAX_KEEP:0]    vld_a;
  logic [DIST_BITS-1:0] dist_a [MAX_KEEP+1];
  logic [IDX_W-1:0]     idx_a  [MAX_KEEP+1];
  logic [MAX_KEEP-1:0]  take_a;

  assign in_tready = !drain_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign new_dist  = in_tdata[DIST_BITS-1:0];

  assign ctl.step = in_acc;
  assign ctl.pop  = out_acc;

  // tail sentinel: empty slot past the last cell
  assign vld_a[MAX_KEEP]  = 1'b0;
  assign dist_a[MAX_KEEP] = '0;
  assign idx_a[MAX_KEEP]  = '0;

  for (genvar gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
    logic                 en;
    logic                 p_valid;
    logic [DIST_BITS-1:0] p_dist;
    logic [IDX_W-1:0]     p_idx;
    logic                 p_take;

    assign en = (gi == 0) || (32'(keep_count_r) > gi);

    if (gi == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_dist  = '0;
      assign p_idx   = '0;
      assign p_take  = 1'b0;
    end else begin : g_body
      assign p_valid = vld_a[gi-1];
      assign p_dist  = dist_a[gi-1];
      assign p_idx   = idx_a[gi-1];
      assign p_take  = take_a[gi-1];
    end

    knsel_cell #(
      .DIST_BITS (DIST_BITS),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .en         (en),
      .new_dist   (new_dist),
      .new_idx    (arr_cnt_r),
      .prev_valid (p_valid),
      .prev_dist  (p_dist),
      .prev_idx   (p_idx),
      .prev_take  (p_take),
      .next_valid (vld_a[gi+1]),
      .next_dist  (dist_a[gi+1]),
      .next_idx   (idx_a[gi+1]),
      .valid_o    (vld_a[gi]),
      .dist_o     (dist_a[gi]),
      .idx_o      (idx_a[gi]),
      .take_o     (take_a[gi])
    );
  end

  always_comb begin
    arr_cnt_nxt = arr_cnt_r;
    drain_nxt   = drain_r;
    if (in_acc) begin
      if (in_tlast) begin
        arr_cnt_nxt = '0;
        drain_nxt   = 1'b1;
      end else if (arr_cnt_r == IDX_WRAP) begin
        arr_cnt_nxt = '0;
      end else begin
        arr_cnt_nxt = arr_cnt_r + 1'b1;
      end
    end
    if (out_acc && out_tlast) begin
      drain_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
      arr_cnt_r    <= '0;
      drain_r      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        keep_count_r <= cfg_wdata;
      end
      arr_cnt_r <= arr_cnt_nxt;
      drain_r   <= drain_nxt;
    end
  end

  assign out_tvalid = drain_r;
  assign out_tlast  = !vld_a[1];
  assign out_tdata  = OUT_W'({dist_a[0], idx_a[0]});

  // kept entries always form a contiguous run from the head
  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_a >> 1) & ~vld_a) == '0)
    else $error("valid cells not contiguous from head");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input open during readout");

  a_final_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (out_tvalid && vld_a[0]))
    else $error("no result after final request");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && !vld_a[0] && arr_cnt_r == '0))
    else $error("chain not cleared after last result");

endmodule

`default_nettype wire

### tb/tb_k_nearest_selector_core.sv
// Testbench for the k-nearest selector core: directed and random sets, scoreboard check.
`default_nettype none

module tb_k_nearest_selector_core;
  import knsel_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_BITS  = 12;
  localparam int unsigned DIST_W    = 32;
  localparam int unsigned OUT_BITS  = 48;
  localparam int unsigned SETTLE    = 4;
  localparam int unsigned RAND_PTS  = 280;

  typedef struct {
    logic [IDX_BITS-1:0] idx;
    logic [DIST_W-1:0]   dval;
    logic                last;
  } pick_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wen = 1'b0;
  logic [KEEP_W-1:0]   cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [DIST_W-1:0]   in_tdata = '0;     // distance
  logic                in_tlast = 1'b0;   // final_item
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;         // point_index, point_distance, zero pad
  logic                out_tlast;         // last_result

  // shadow of the selector state
  logic [KEEP_W-1:0]   keep_shadow;
  logic [DIST_W-1:0]   near_dist [MAX_KEEP_DEF];
  logic [IDX_BITS-1:0] near_idx  [MAX_KEEP_DEF];
  int                  near_fill;
  logic [IDX_BITS-1:0] arrival_pos;

  pick_t picks_q[$];
  pick_t want_pick;

  int err_count     = 0;
  int sets_done     = 0;
  int points_sent   = 0;
  int picks_checked = 0;
  int cfg_writes    = 0;
  int burst_left    = 0;
  int ready_left    = 0;
  int ready_mode    = 0;

  k_nearest_selector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // insert one point into the shadow list; on the final point queue the readout
  task automatic select_point(input logic [DIST_W-1:0] dval, input logic fin);
    int    k;
    int    pos;
    int    j;
    pick_t p;
    k = keep_shadow;
    if (k == 0) k = 1;
    if (k > MAX_KEEP_DEF) k = MAX_KEEP_DEF;
    if (near_fill > k) near_fill = k;
    // full list: a distance equal to the worst kept one loses to the earlier point
    if (!(near_fill >= k && dval >= near_dist[k-1])) begin
      pos = 0;
      while (pos < near_fill && near_dist[pos] <= dval) pos++;
      j = (near_fill < k) ? near_fill : k - 1;
      while (j > pos) begin
        near_dist[j] = near_dist[j-1];
        near_idx[j]  = near_idx[j-1];
        j--;
      end
      near_dist[pos] = dval;
      near_idx[pos]  = arrival_pos;
      if (near_fill < k) near_fill++;
    end
    arrival_pos = arrival_pos + 1'b1;
    if (fin) begin
      for (int i = 0; i < near_fill; i++) begin
        p.idx  = near_idx[i];
        p.dval = near_dist[i];
        p.last = (i == near_fill - 1);
        picks_q.push_back(p);
      end
      near_fill   = 0;
      arrival_pos = '0;
      sets_done++;
    end
  endtask

  // one input request, with bursty idling in front of it
  task automatic send_point(input logic [DIST_W-1:0] dval, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dval;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    select_point(dval, fin);
    points_sent++;
    burst_left--;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (picks_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] value);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    keep_shadow = value;
    cfg_writes++;
  endtask

  task automatic test_short_set;
    send_point(32'hFFFF_FFFF, 1'b0);
    send_point(32'h0000_0000, 1'b0);
    send_point(32'd5, 1'b1);
    send_point(32'h8000_0001, 1'b1);
  endtask

  task automatic test_tie_with_worst;
    write_keep(5'd2);
    send_point(32'd7, 1'b0);
    send_point(32'd7, 1'b0);
    send_point(32'd7, 1'b0);
    send_point(32'd3, 1'b0);
    send_point(32'd7, 1'b1);
  endtask

  task automatic test_keep_zero;
    write_keep(5'd0);
    send_point(32'd9, 1'b0);
    send_point(32'd4, 1'b0);
    send_point(32'd4, 1'b1);
  endtask

  task automatic test_keep_saturate;
    write_keep(5'd31);
    for (int p = 0; p < 18; p++) send_point(32'd18 - p, p == 17);
  endtask

  task automatic test_lower_mid_set;
    write_keep(5'd8);
    for (int p = 0; p < 6; p++) send_point($urandom_range(0, 255), 1'b0);
    write_keep(5'd3);
    send_point(32'd100, 1'b0);
    send_point(32'd1, 1'b1);
  endtask

  task automatic test_random_sets;
    int                n;
    int                style;
    int                sent;
    int                wcount;
    logic [DIST_W-1:0] d;
    logic [KEEP_W-1:0] kv;
    logic [KEEP_W-1:0] extremes [4];
    extremes = '{5'd1, 5'd16, 5'd0, 5'd31};
    sent   = 0;
    wcount = 0;
    while (sent < RAND_PTS) begin
      if (wcount < 4 || $urandom_range(0, 3) == 0) begin
        kv = (wcount < 4) ? extremes[wcount] : KEEP_W'($urandom_range(0, 31));
        write_keep(kv);
        wcount++;
      end
      n     = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
      style = $urandom_range(0, 3);
      for (int p = 0; p < n; p++) begin
        if (p == n / 2 && n > 2 && $urandom_range(0, 9) == 0)
          write_keep(KEEP_W'($urandom_range(0, 31)));
        case (style)
          0:       d = $urandom;
          1:       d = $urandom_range(0, 7);
          2:       d = 32'hFFFF_FFF0 | $urandom_range(0, 15);
          default: begin
            case ($urandom_range(0, 3))
              0:       d = '0;
              1:       d = '1;
              default: d = $urandom;
            endcase
          end
        endcase
        send_point(d, p == n - 1);
        sent++;
      end
    end
  endtask

  // receiver: stretches of always-ready, random stalls and heavy stalls
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(8, 40);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (picks_q.size() == 0) begin
        $error("unexpected result: point_index %0d point_distance %0h",
               out_tdata[IDX_BITS-1:0], out_tdata[IDX_BITS+DIST_W-1:IDX_BITS]);
        err_count++;
      end else begin
        want_pick = picks_q.pop_front();
        picks_checked++;
        if (out_tdata[IDX_BITS-1:0] !== want_pick.idx) begin
          $error("point_index: expected %0d, got %0d", want_pick.idx, out_tdata[IDX_BITS-1:0]);
          err_count++;
        end
        if (out_tdata[IDX_BITS+DIST_W-1:IDX_BITS] !== want_pick.dval) begin
          $error("point_distance: expected %0h, got %0h", want_pick.dval,
                 out_tdata[IDX_BITS+DIST_W-1:IDX_BITS]);
          err_count++;
        end
        if (out_tlast !== want_pick.last) begin
          $error("last_result: expected %0b, got %0b", want_pick.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin
    keep_shadow = KEEP_RESET;
    near_fill   = 0;
    arrival_pos = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_set();
    test_tie_with_worst();
    test_keep_zero();
    test_keep_saturate();
    test_lower_mid_set();
    test_random_sets();

    drain();
    repeat (20) @(posedge clk);
    $display("ran %0d sets from %0d points with %0d keep_count writes", sets_done,
             points_sent, cfg_writes);
    $display("checked %0d selected points, %0d mismatches", picks_checked, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
